// ----- rtl/tcft_pkg.sv -----
// ----------------------------------------------------------------------------
// tcft_pkg: shared types and constants
// Types, constants and tables for the trot cycloid foot trajectory generator.
// ----------------------------------------------------------------------------
package tcft_pkg;

	localparam int CordicStepsDef = 16;
	localparam int PosFracBitsDef = 8;
	localparam int CordicTableLen = 24;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_START  = 2'd1;
	localparam logic [1:0] OP_STOP   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] REG_LIFT   = 3'd0;
	localparam logic [2:0] REG_STRIDE = 3'd1;
	localparam logic [2:0] REG_PERIOD = 3'd2;
	localparam logic [2:0] REG_BASE0  = 3'd3;
	localparam logic [2:0] REG_BASE1  = 3'd4;
	localparam logic [2:0] REG_BASE2  = 3'd5;
	localparam logic [2:0] REG_BASE3  = 3'd6;

	localparam logic signed [33:0] CordicStart  = 34'sd652032874;
	localparam logic signed [33:0] InvTwoPiQ32  = 34'sd683565276;

	typedef enum logic [3:0] {
		ST_IDLE, ST_MOD, ST_DIV, ST_CORDIC, ST_QUAD,
		ST_MUL_F, ST_SWX, ST_SWY, ST_STX, ST_OUT
	} state_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] i);
		case (i)
			5'd0:  atan_turn = 32'h20000000;
			5'd1:  atan_turn = 32'h12E4051E;
			5'd2:  atan_turn = 32'h09FB385B;
			5'd3:  atan_turn = 32'h051111D4;
			5'd4:  atan_turn = 32'h028B0D43;
			5'd5:  atan_turn = 32'h0145D7E1;
			5'd6:  atan_turn = 32'h00A2F61E;
			5'd7:  atan_turn = 32'h00517C55;
			5'd8:  atan_turn = 32'h0028BE53;
			5'd9:  atan_turn = 32'h00145F2F;
			5'd10: atan_turn = 32'h000A2F98;
			5'd11: atan_turn = 32'h000517CC;
			5'd12: atan_turn = 32'h00028BE6;
			5'd13: atan_turn = 32'h000145F3;
			5'd14: atan_turn = 32'h0000A2FA;
			5'd15: atan_turn = 32'h0000517D;
			5'd16: atan_turn = 32'h000028BE;
			5'd17: atan_turn = 32'h0000145F;
			5'd18: atan_turn = 32'h00000A30;
			5'd19: atan_turn = 32'h00000518;
			5'd20: atan_turn = 32'h0000028C;
			5'd21: atan_turn = 32'h00000146;
			5'd22: atan_turn = 32'h000000A3;
			5'd23: atan_turn = 32'h00000051;
			default: atan_turn = 32'h0;
		endcase
	endfunction

endpackage

// ----- rtl/trot_cycloid_foot_trajectory_top.sv -----
// ----------------------------------------------------------------------------
// trot_cycloid_foot_trajectory_top
// Trot gait foot-target generator: restoring divider, shared CORDIC and a
// shared multiplier under one sequencer, four legs of cycloid swing targets.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  s_axis  | in        | s_axis_tvalid/tready   | tdata: opcode, now_ms, motors_ready
//  m_axis  | out       | m_axis_tvalid/tready   | tdata: status, phase, foot x/y
//  cfg     | in        | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
//  a start, stop, unused, idle or aborting tick request goes from idle straight to output
//  a running tick steps through modulo, phase divide, the CORDIC loop, quadrant,
//  four multiply steps and output, paced by the one-bit-per-cycle divider and the CORDIC loop
//  one request at a time: s_axis_tready is low from accept until the result
//  has been taken on m_axis; reset clears gait state and registers to defaults
// ----------------------------------------------------------------------------
module trot_cycloid_foot_trajectory_top #(
	parameter int CORDIC_STEPS  = tcft_pkg::CordicStepsDef,
	parameter int POS_FRAC_BITS = tcft_pkg::PosFracBitsDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [1:0] opcode, [33:2] now_ms, [41:34] motors_ready, zero fill
	input  logic [47:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [0] running, [1] aborted, [2] second_half, [18:3] phase,
	// then foot_x_leg0..3, foot_y_leg0..3, each 9+POS_FRAC_BITS, zero fill
	output logic [((19 + 8 * (9 + POS_FRAC_BITS)) + 7) / 8 * 8 - 1:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	import tcft_pkg::*;

	localparam int PosBits = 9 + POS_FRAC_BITS;
	localparam int OutBits = 19 + 8 * PosBits;
	localparam int OutW    = (OutBits + 7) / 8 * 8;
	localparam int StepW   = $clog2(CORDIC_STEPS + 1);
	// intermediate positions are signed Q11.8 values (default parameters) before saturation
	localparam int WideW   = (PosBits + 2 > 19) ? PosBits + 2 : 19;
	localparam logic signed [PosBits-1:0] PosMax = {1'b0, {(PosBits-1){1'b1}}};
	localparam logic signed [PosBits-1:0] PosMin = {1'b1, {(PosBits-1){1'b0}}};

	// configuration registers
	logic [14:0] lift_q, stride_q;
	logic [15:0] period_q;
	logic [PosBits-1:0] base_q [4];

	// gait state
	logic        active_q;
	logic [31:0] start_q;

	state_t state_q, state_d;

	logic [1:0]  op_q;
	logic [7:0]  rdy_q;

	// divider: remainder / quotient shift register
	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic [16:0] hp_q;

	// cordic
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [StepW-1:0]   ci_q;

	logic        second_q;
	logic [15:0] phase_q;
	logic signed [33:0] cos_q, sin_q;
	logic signed [33:0] f_q;
	logic signed [WideW-1:0] swx_q, swy_q, stx_q;
	logic        aborted_q, valid_q;
	logic [OutW-1:0] out_q;

	// shared multiplier, 34 x 34 signed operands
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mul_p;
	assign mul_p = mul_a * mul_b;

	assign cfg_ready     = (state_q == ST_IDLE) && !valid_q;
	assign s_axis_tready = (state_q == ST_IDLE) && !valid_q;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = out_q;

	function automatic logic signed [33:0] fshr(input logic signed [33:0] v,
		input logic [StepW-1:0] s);
		fshr = v >>> s;
	endfunction

	function automatic logic signed [PosBits-1:0] sat(input logic signed [WideW-1:0] v);
		if (v > WideW'(PosMax)) sat = PosMax;
		else if (v < WideW'(PosMin)) sat = PosMin;
		else sat = v[PosBits-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lift_q   <= 15'd20480;
			stride_q <= 15'd12800;
			period_q <= 16'd400;
			for (int k = 0; k < 4; k++) base_q[k] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LIFT:   lift_q   <= cfg_data[14:0];
				REG_STRIDE: stride_q <= cfg_data[14:0];
				REG_PERIOD: period_q <= cfg_data[15:0];
				REG_BASE0:  base_q[0] <= cfg_data[PosBits-1:0];
				REG_BASE1:  base_q[1] <= cfg_data[PosBits-1:0];
				REG_BASE2:  base_q[2] <= cfg_data[PosBits-1:0];
				REG_BASE3:  base_q[3] <= cfg_data[PosBits-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// divider step: shift in one dividend bit and subtract if it fits
	logic [33:0] div_sh;
	logic [33:0] div_dv;
	logic        div_ge;
	always_comb begin
		div_dv = (state_q == ST_MOD) ? {16'd0, hp_q, 1'b0} : {17'd0, hp_q};
		div_sh = {rem_q, quo_q[31]};
		div_ge = div_sh >= div_dv;
	end

	always_comb begin
		state_d = state_q;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tdata[1:0] == OP_TICK && active_q && s_axis_tdata[41:34] == 8'hFF)
					state_d = ST_MOD;
				else
					state_d = ST_OUT;
			end
			ST_MOD: if (cnt_q == 6'd31) state_d = ST_DIV;
			ST_DIV: if (cnt_q == 6'd31) state_d = ST_CORDIC;
			ST_CORDIC: if (ci_q == StepW'(CORDIC_STEPS - 1)) state_d = ST_QUAD;
			ST_QUAD: state_d = ST_MUL_F;
			ST_MUL_F: begin
				mul_a = sin_q;
				mul_b = InvTwoPiQ32;
				state_d = ST_SWX;
			end
			ST_SWX: begin
				mul_a = {18'd0, stride_q, 1'b0};
				mul_b = f_q;
				state_d = ST_SWY;
			end
			ST_SWY: begin
				mul_a = {19'd0, lift_q};
				mul_b = 34'sd1073741824 - cos_q;
				state_d = ST_STX;
			end
			ST_STX: begin
				mul_a = {18'd0, stride_q, 1'b0};
				mul_b = {18'd0, phase_q};
				state_d = ST_OUT;
			end
			ST_OUT: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			start_q   <= '0;
			valid_q   <= 1'b0;
			aborted_q <= 1'b0;
			cnt_q     <= '0;
			ci_q      <= '0;
		end else begin
			if (valid_q && m_axis_tready) valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					op_q  <= s_axis_tdata[1:0];
					rdy_q <= s_axis_tdata[41:34];
					// a tick with any motor not ready stops a running gait
					aborted_q <= (s_axis_tdata[1:0] == OP_TICK) && active_q &&
						(s_axis_tdata[41:34] != 8'hFF);
					second_q  <= 1'b0;
					phase_q   <= '0;
					hp_q <= {1'b0, (period_q == 16'd0) ? 16'd1 : period_q};
					rem_q <= '0;
					quo_q <= s_axis_tdata[33:2] - start_q;
					cnt_q <= '0;
					case (s_axis_tdata[1:0])
						OP_START: if (!active_q) begin
							active_q <= 1'b1;
							start_q  <= s_axis_tdata[33:2];
						end
						OP_STOP: active_q <= 1'b0;
						OP_TICK: if (active_q && s_axis_tdata[41:34] != 8'hFF)
							active_q <= 1'b0;
						default: ;
					endcase
				end
				ST_MOD: begin
					if (cnt_q == 6'd31) begin
						// remainder of elapsed mod 2*hp, split into half and phase
						logic [33:0] r;
						r = div_ge ? div_sh - div_dv : div_sh;
						if (r[32:0] >= {16'd0, hp_q}) begin
							second_q <= 1'b1;
							quo_q <= {r[15:0] - hp_q[15:0], 16'd0};
						end else begin
							second_q <= 1'b0;
							quo_q <= {r[15:0], 16'd0};
						end
						rem_q <= '0;
						cnt_q <= '0;
					end else begin
						rem_q <= div_ge ? 33'(div_sh - div_dv) : div_sh[32:0];
						quo_q <= {quo_q[30:0], 1'b0};
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					rem_q <= div_ge ? 33'(div_sh - div_dv) : div_sh[32:0];
					quo_q <= {quo_q[30:0], div_ge};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						phase_q <= {quo_q[14:0], div_ge};
						cx_q <= CordicStart;
						cy_q <= '0;
						cz_q <= {2'b00, quo_q[12:0], div_ge, 18'd0};
						ci_q <= '0;
					end
				end
				ST_CORDIC: begin
					if (!cz_q[33]) begin
						cx_q <= cx_q - fshr(cy_q, ci_q);
						cy_q <= cy_q + fshr(cx_q, ci_q);
						cz_q <= cz_q - $signed({2'b00, atan_turn(5'(ci_q))});
					end else begin
						cx_q <= cx_q + fshr(cy_q, ci_q);
						cy_q <= cy_q - fshr(cx_q, ci_q);
						cz_q <= cz_q + $signed({2'b00, atan_turn(5'(ci_q))});
					end
					ci_q <= ci_q + StepW'(1);
				end
				ST_QUAD: begin
					case (phase_q[15:14])
						2'd0: begin cos_q <= cx_q;  sin_q <= cy_q;  end
						2'd1: begin cos_q <= -cy_q; sin_q <= cx_q;  end
						2'd2: begin cos_q <= -cx_q; sin_q <= -cy_q; end
						default: begin cos_q <= cy_q; sin_q <= -cx_q; end
					endcase
				end
				ST_MUL_F: f_q <= $signed({2'b00, phase_q, 16'd0} >> 2) - mul_p[65:32];
				ST_SWX: begin
					logic signed [67:0] v;
					v = mul_p + 68'sd536870912;
					swx_q <= WideW'(-$signed({1'b0, stride_q}) + (v >>> 30));
				end
				ST_SWY: begin
					logic signed [67:0] v;
					v = mul_p + 68'sd1073741824;
					swy_q <= WideW'(v >>> 31);
				end
				ST_STX: begin
					logic signed [67:0] v;
					v = mul_p + 68'sd32768;
					stx_q <= WideW'($signed({1'b0, stride_q}) - (v >>> 16));
				end
				ST_OUT: begin
					logic run_tick;
					logic [OutW-1:0] o;
					logic signed [WideW-1:0] b;
					logic sw;
					run_tick = (op_q == OP_TICK) && active_q && !aborted_q && (rdy_q == 8'hFF);
					o = '0;
					o[0] = active_q;
					o[1] = aborted_q;
					if (run_tick) begin
						o[2] = second_q;
						o[18:3] = phase_q;
						for (int k = 0; k < 4; k++) begin
							sw = (k == 0 || k == 3) ? second_q : !second_q;
							b = WideW'($signed(base_q[k]));
							o[19 + k*PosBits +: PosBits] = sat(sw ? swx_q : stx_q);
							o[19 + (4+k)*PosBits +: PosBits] = sat(sw ? b - swy_q : b);
						end
					end
					out_q <= o;
					valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// ----- rtl/tcft_checker.sv -----
// ----------------------------------------------------------------------------
// tcft_checker: port-level assertions
// Watches the stream and configuration ports of the gait generator.
// ----------------------------------------------------------------------------
module tcft_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic        cfg_ready,
	input logic [19:0] m_head
);
	// one request in flight: no input accepted while a result waits
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
	// a result can't be both aborted and running
	a_abort: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_head[1] |-> !m_head[0]) else $error("aborted yet running");
	// no trajectory on an idle result
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_head[0] |-> m_head[18:2] == 17'd0)
		else $error("trajectory fields on idle result");
	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_head))
		else $error("result dropped under stall");
	// config and input ready move together
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready == s_axis_tready) else $error("config ready mismatch");
endmodule

bind trot_cycloid_foot_trajectory_top tcft_checker u_tcft_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.cfg_ready(cfg_ready), .m_head(m_axis_tdata[19:0])
);
